@@ rtl/npst_pkg.sv @@
// Shared types, codes and microprogram for the next-prime stepper.
`timescale 1ns / 1ps

package npst_pkg;

  // Default operand width
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Action codes of a request
  localparam logic [1:0] ACT_STEP      = 2'd0;
  localparam logic [1:0] ACT_STEP_FROM = 2'd1;
  localparam logic [1:0] ACT_SET       = 2'd2;
  localparam logic [1:0] ACT_NONE      = 2'd3;

  // Datapath operation codes
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP     = 4'd0;
  localparam op_t OP_SEL     = 4'd1;
  localparam op_t OP_INITC   = 4'd2;
  localparam op_t OP_ADVC    = 4'd3;
  localparam op_t OP_DIVINIT = 4'd4;
  localparam op_t OP_DIVSTEP = 4'd5;
  localparam op_t OP_NEXTD   = 4'd6;
  localparam op_t OP_SETCUR  = 4'd7;
  localparam op_t OP_EMIT2   = 4'd8;
  localparam op_t OP_EMIT3   = 4'd9;
  localparam op_t OP_EMITOVF = 4'd10;
  localparam op_t OP_EMITC   = 4'd11;

  // Jump condition codes
  typedef logic [3:0] cond_t;
  localparam cond_t C_NEXT   = 4'd0;
  localparam cond_t C_ALWAYS = 4'd1;
  localparam cond_t C_NSTART = 4'd2;
  localparam cond_t C_NOP    = 4'd3;
  localparam cond_t C_SET    = 4'd4;
  localparam cond_t C_LT2    = 4'd5;
  localparam cond_t C_EQ2    = 4'd6;
  localparam cond_t C_OVF    = 4'd7;
  localparam cond_t C_SQGT   = 4'd8;
  localparam cond_t C_NLAST  = 4'd9;
  localparam cond_t C_REMZ   = 4'd10;

  // Step counter
  localparam int unsigned PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  // Step addresses
  localparam pc_t PC_IDLE    = 5'd0;
  localparam pc_t PC_CHKNONE = 5'd1;
  localparam pc_t PC_CHKSET  = 5'd2;
  localparam pc_t PC_SELECT  = 5'd3;
  localparam pc_t PC_CHKLT2  = 5'd4;
  localparam pc_t PC_CHKEQ2  = 5'd5;
  localparam pc_t PC_INITC   = 5'd6;
  localparam pc_t PC_NEXTC   = 5'd7;
  localparam pc_t PC_TESTSQ  = 5'd8;
  localparam pc_t PC_DIVIDE  = 5'd9;
  localparam pc_t PC_CHECK   = 5'd10;
  localparam pc_t PC_LOOPD   = 5'd11;
  localparam pc_t PC_SET     = 5'd12;
  localparam pc_t PC_EMIT2   = 5'd13;
  localparam pc_t PC_EMIT3   = 5'd14;
  localparam pc_t PC_OVF     = 5'd15;
  localparam pc_t PC_PRIME   = 5'd16;

  // One control word
  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } cw_t;

  // Sequencer to datapath
  typedef struct packed {
    logic accept;
    op_t  op;
  } ctrl_t;

  // Datapath flags for jumps
  typedef struct packed {
    logic is_none;
    logic is_set;
    logic lt2;
    logic eq2;
    logic ovf;
    logic sq_gt;
    logic not_last;
    logic rem_zero;
  } stat_t;

  // Microprogram store
  function automatic cw_t ucode_rom(input pc_t pc);
    cw_t cw;
    cw = '{op: OP_NOP, cond: C_ALWAYS, target: PC_IDLE};
    case (pc)
      PC_IDLE:    cw = '{op: OP_NOP,     cond: C_NSTART, target: PC_IDLE};
      PC_CHKNONE: cw = '{op: OP_NOP,     cond: C_NOP,    target: PC_IDLE};
      PC_CHKSET:  cw = '{op: OP_NOP,     cond: C_SET,    target: PC_SET};
      PC_SELECT:  cw = '{op: OP_SEL,     cond: C_NEXT,   target: PC_IDLE};
      PC_CHKLT2:  cw = '{op: OP_NOP,     cond: C_LT2,    target: PC_EMIT2};
      PC_CHKEQ2:  cw = '{op: OP_NOP,     cond: C_EQ2,    target: PC_EMIT3};
      PC_INITC:   cw = '{op: OP_INITC,   cond: C_NEXT,   target: PC_IDLE};
      PC_NEXTC:   cw = '{op: OP_ADVC,    cond: C_OVF,    target: PC_OVF};
      PC_TESTSQ:  cw = '{op: OP_DIVINIT, cond: C_SQGT,   target: PC_PRIME};
      PC_DIVIDE:  cw = '{op: OP_DIVSTEP, cond: C_NLAST,  target: PC_DIVIDE};
      PC_CHECK:   cw = '{op: OP_NEXTD,   cond: C_REMZ,   target: PC_NEXTC};
      PC_LOOPD:   cw = '{op: OP_NOP,     cond: C_ALWAYS, target: PC_TESTSQ};
      PC_SET:     cw = '{op: OP_SETCUR,  cond: C_ALWAYS, target: PC_IDLE};
      PC_EMIT2:   cw = '{op: OP_EMIT2,   cond: C_ALWAYS, target: PC_IDLE};
      PC_EMIT3:   cw = '{op: OP_EMIT3,   cond: C_ALWAYS, target: PC_IDLE};
      PC_OVF:     cw = '{op: OP_EMITOVF, cond: C_ALWAYS, target: PC_IDLE};
      PC_PRIME:   cw = '{op: OP_EMITC,   cond: C_ALWAYS, target: PC_IDLE};
      default:    cw = '{op: OP_NOP,     cond: C_ALWAYS, target: PC_IDLE};
    endcase
    return cw;
  endfunction

endpackage

@@ rtl/npst_seq.sv @@
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps

module npst_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  npst_pkg::stat_t stat,
  output npst_pkg::ctrl_t ctrl,
  output logic            busy
);

  npst_pkg::pc_t pc_r, pc_nxt;
  npst_pkg::cw_t cw;
  logic          take;

  assign cw = npst_pkg::ucode_rom(pc_r);

  // Jump condition select
  always_comb begin
    case (cw.cond)
      npst_pkg::C_NEXT:   take = 1'b0;
      npst_pkg::C_ALWAYS: take = 1'b1;
      npst_pkg::C_NSTART: take = !start;
      npst_pkg::C_NOP:    take = stat.is_none;
      npst_pkg::C_SET:    take = stat.is_set;
      npst_pkg::C_LT2:    take = stat.lt2;
      npst_pkg::C_EQ2:    take = stat.eq2;
      npst_pkg::C_OVF:    take = stat.ovf;
      npst_pkg::C_SQGT:   take = stat.sq_gt;
      npst_pkg::C_NLAST:  take = stat.not_last;
      npst_pkg::C_REMZ:   take = stat.rem_zero;
      default:            take = 1'b1;
    endcase
  end

  assign pc_nxt = take ? cw.target : pc_r + npst_pkg::pc_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= npst_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign busy        = (pc_r != npst_pkg::PC_IDLE);
  assign ctrl.accept = start && !busy;
  assign ctrl.op     = cw.op;

endmodule

@@ rtl/npst_dpath.sv @@
// Datapath: stored value, candidate, odd divisor with running square, serial remainder.
`timescale 1ns / 1ps

module npst_dpath #(
  parameter int unsigned VALUE_WIDTH = npst_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  npst_pkg::ctrl_t               ctrl,
  input  logic [1:0]                    in_action,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output npst_pkg::stat_t               stat,
  output logic                          out_valid,
  output logic [VALUE_WIDTH-1:0]        out_prime,
  output logic                          out_overflow
);

  localparam int unsigned W     = VALUE_WIDTH;
  localparam int unsigned CNT_W = $clog2(W);
  // Largest candidate that can still step by two
  localparam logic [W-1:0] CAND_MAX = {{(W-2){1'b1}}, 2'b01};

  logic [1:0]        act_r, act_nxt;
  logic [W-1:0]      val_r, val_nxt;
  logic signed [W:0] cur_r, cur_nxt;
  logic signed [W:0] strt_r, strt_nxt;
  logic [W-1:0]      cand_r, cand_nxt;
  logic [W-1:0]      div_r, div_nxt;
  logic [W+1:0]      sq_r, sq_nxt;
  logic [W-1:0]      rem_r, rem_nxt;
  logic [W-1:0]      dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              vld_r, vld_nxt;
  logic [W-1:0]      prime_r, prime_nxt;
  logic              ovf_r, ovf_nxt;

  logic [W:0]        shf;
  logic [W:0]        diff;
  logic              ge;

  // One restoring remainder step
  assign shf  = {rem_r, dvd_r[W-1]};
  assign diff = shf - {1'b0, div_r};
  assign ge   = (shf >= {1'b0, div_r});

  always_comb begin
    act_nxt   = act_r;
    val_nxt   = val_r;
    cur_nxt   = cur_r;
    strt_nxt  = strt_r;
    cand_nxt  = cand_r;
    div_nxt   = div_r;
    sq_nxt    = sq_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    cnt_nxt   = cnt_r;
    vld_nxt   = 1'b0;
    prime_nxt = prime_r;
    ovf_nxt   = ovf_r;

    if (ctrl.accept) begin
      act_nxt = in_action;
      val_nxt = in_value;
    end

    case (ctrl.op)
      npst_pkg::OP_SEL: begin
        strt_nxt = (act_r == npst_pkg::ACT_STEP) ? cur_r : $signed({val_r[W-1], val_r});
      end
      npst_pkg::OP_INITC: begin
        cand_nxt = strt_r[0] ? strt_r[W-1:0] : strt_r[W-1:0] - W'(1);
      end
      npst_pkg::OP_ADVC: begin
        cand_nxt = cand_r + W'(2);
        div_nxt  = W'(3);
        sq_nxt   = (W+2)'(9);
      end
      npst_pkg::OP_DIVINIT: begin
        rem_nxt = '0;
        dvd_nxt = cand_r;
        cnt_nxt = '0;
      end
      npst_pkg::OP_DIVSTEP: begin
        rem_nxt = ge ? diff[W-1:0] : shf[W-1:0];
        dvd_nxt = {dvd_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      npst_pkg::OP_NEXTD: begin
        // (d+2)^2 = d^2 + 4d + 4
        div_nxt = div_r + W'(2);
        sq_nxt  = sq_r + {div_r, 2'b00} + (W+2)'(4);
      end
      npst_pkg::OP_SETCUR: begin
        cur_nxt = $signed({val_r[W-1], val_r});
      end
      npst_pkg::OP_EMIT2: begin
        cur_nxt   = (W+1)'(2);
        prime_nxt = W'(2);
        ovf_nxt   = 1'b0;
        vld_nxt   = 1'b1;
      end
      npst_pkg::OP_EMIT3: begin
        cur_nxt   = (W+1)'(3);
        prime_nxt = W'(3);
        ovf_nxt   = 1'b0;
        vld_nxt   = 1'b1;
      end
      npst_pkg::OP_EMITOVF: begin
        prime_nxt = '0;
        ovf_nxt   = 1'b1;
        vld_nxt   = 1'b1;
      end
      npst_pkg::OP_EMITC: begin
        cur_nxt   = $signed({1'b0, cand_r});
        prime_nxt = cand_r;
        ovf_nxt   = 1'b0;
        vld_nxt   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control and stored value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= npst_pkg::ACT_NONE;
      cur_r <= '0;
      vld_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
      cur_r <= cur_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    strt_r  <= strt_nxt;
    cand_r  <= cand_nxt;
    div_r   <= div_nxt;
    sq_r    <= sq_nxt;
    rem_r   <= rem_nxt;
    dvd_r   <= dvd_nxt;
    cnt_r   <= cnt_nxt;
    prime_r <= prime_nxt;
    ovf_r   <= ovf_nxt;
  end

  // Flags for the sequencer
  assign stat.is_none  = (act_r == npst_pkg::ACT_NONE);
  assign stat.is_set   = (act_r == npst_pkg::ACT_SET);
  assign stat.lt2      = (strt_r < $signed((W+1)'(2)));
  assign stat.eq2      = (strt_r == $signed((W+1)'(2)));
  assign stat.ovf      = (cand_r > CAND_MAX);
  assign stat.sq_gt    = (sq_r > {2'b00, cand_r});
  assign stat.not_last = (cnt_r != CNT_W'(W-1));
  assign stat.rem_zero = (rem_r == '0);

  assign out_valid    = vld_r;
  assign out_prime    = prime_r;
  assign out_overflow = ovf_r;

endmodule

@@ rtl/next_prime_stepper_core.sv @@
// Top level of the next-prime stepper: sequencer plus datapath.
`timescale 1ns / 1ps
// Usage:
//   A request (in_action, in_value) is taken at a rising edge with start high and
//   busy low. Action step advances the stored value to the next prime, step_from
//   does so from in_value, set stores in_value and gives no result, code 3 is a
//   no-op. A result appears on out_prime/out_overflow for exactly one cycle with
//   out_valid high; the receiver cannot stall it. On overflow out_prime is 0,
//   out_overflow is 1 and the stored value is kept.
// Timing:
//   After the accepting edge busy stays high until the request is done. A no-op
//   ends soonest, then a set; a step from below 2 or from 2 needs no division.
//   Any other step tries odd candidates, each against the odd divisors with
//   d*d <= candidate, so its length rests on the serial remainder unit, one bit
//   per cycle, and on how many divisors are tried.
//   The result strobes in the first cycle with busy low, and the next request
//   can be taken at the edge that ends that cycle. One request is in flight.
// Reset:
//   Synchronous, active low. Clears the stored value to 0 and returns the
//   sequencer to idle; no result is pending after reset.
module next_prime_stepper_core #(
  parameter int unsigned VALUE_WIDTH = npst_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_action,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  output logic [VALUE_WIDTH-1:0]        out_prime,
  output logic                          out_overflow
);

  npst_pkg::ctrl_t ctrl;
  npst_pkg::stat_t stat;

  npst_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  npst_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .in_action    (in_action),
    .in_value     (in_value),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_prime    (out_prime),
    .out_overflow (out_overflow)
  );

`ifndef ASSERT_OFF
  // An accepted request always occupies the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.accept |=> busy)
    else $error("request accepted but sequencer stayed idle");

  // Results never come back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Overflow results carry a zero prime
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_prime == '0))
    else $error("overflow result with nonzero prime");

  // A good result is at least two
  a_prime_min: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_overflow) |-> (out_prime >= VALUE_WIDTH'(2)))
    else $error("prime result below two");
`endif

endmodule

@@ verif/tb_next_prime_stepper_core.sv @@
// Self-checking testbench for the next-prime stepper core.
`timescale 1ns / 1ps

module tb_next_prime_stepper_core;

  localparam int unsigned VW = npst_pkg::VALUE_WIDTH_DEF;

  // One predicted result of a step request
  typedef struct packed {
    logic [VW-1:0] prime;
    logic          overflow;
  } prime_result_t;

  // Tracks the stored value, predicts primes and checks the result strobes
  class prime_scoreboard;
    longint        stored_value;
    prime_result_t pending_results[$];
    int            mismatches;
    int            results_checked;
    int            act_counts[4];
    int            negative_starts;
    longint unsigned largest_prime;

    function new();
      stored_value = 0;
      mismatches = 0;
      results_checked = 0;
      negative_starts = 0;
      largest_prime = 0;
      foreach (act_counts[i]) act_counts[i] = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void flag(string what, longint unsigned want, longint unsigned got);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    endfunction

    // Odd candidate test: odd divisors while d*d <= c
    function bit odd_is_prime(longint unsigned c);
      longint unsigned d;
      for (d = 3; d <= c / d; d += 2) begin
        if (c % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Smallest prime above start_v; returns 0 when none fits in VW bits
    function bit next_prime_above(longint start_v, output longint unsigned p);
      longint unsigned top;
      longint unsigned c;
      top = (64'd1 << VW) - 64'd1;
      p = 0;
      if (start_v < 2) begin
        p = 2;
        return 1'b1;
      end
      if (start_v == 2) begin
        p = 3;
        return 1'b1;
      end
      c = start_v;
      if (c[0] == 1'b0) c -= 1;
      forever begin
        if (c > top - 2) return 1'b0;
        c += 2;
        if (odd_is_prime(c)) begin
          p = c;
          return 1'b1;
        end
      end
    endfunction

    // Called for every accepted request
    function void note_request(logic [1:0] act, logic [VW-1:0] val);
      longint          given;
      longint          start_v;
      longint unsigned p;
      prime_result_t   r;
      given = $signed(val);
      act_counts[act]++;
      if (act == npst_pkg::ACT_SET) begin
        stored_value = given;
        return;
      end
      if (act == npst_pkg::ACT_NONE) return;
      start_v = (act == npst_pkg::ACT_STEP) ? stored_value : given;
      if (start_v < 0) negative_starts++;
      if (next_prime_above(start_v, p)) begin
        stored_value = p;
        r.prime = p[VW-1:0];
        r.overflow = 1'b0;
        if (p > largest_prime) largest_prime = p;
      end else begin
        r.prime = '0;
        r.overflow = 1'b1;
      end
      pending_results.push_back(r);
    endfunction

    // Called for every result strobe
    function void check_result(logic [VW-1:0] prime, logic overflow);
      prime_result_t want;
      if (pending_results.size() == 0) begin
        flag("result with nothing pending, prime", 0, prime);
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (prime !== want.prime) flag("prime", want.prime, prime);
      if (overflow !== want.overflow) flag("overflow", want.overflow, overflow);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic [1:0]           in_action = npst_pkg::ACT_NONE;
  logic signed [VW-1:0] in_value = '0;
  logic                 busy;
  logic                 out_valid;
  logic [VW-1:0]        out_prime;
  logic                 out_overflow;

  prime_scoreboard sb;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  next_prime_stepper_core #(.VALUE_WIDTH(VW)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_prime    (out_prime),
    .out_overflow (out_overflow)
  );

  // Result monitor: the strobe is taken at the edge that ends its cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_prime, out_overflow);
  end

  // Drive one request, holding start high until it is taken
  task automatic issue_request(input logic [1:0] act, input logic [VW-1:0] val,
                               input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_value <= val;
    do @(posedge clk); while (busy);
    sb.note_request(act, val);
  endtask

  // Hold off until every predicted result has been seen
  task automatic wait_results_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Start values: mostly small so trial division stays short
  function automatic logic [VW-1:0] pick_value();
    logic [VW-1:0] v;
    int unsigned   r;
    r = $urandom_range(0, 99);
    if (r < 40) v = $urandom_range(0, 4095);
    else if (r < 55) v = $urandom_range(0, 65535);
    else if (r < 60) v = $urandom_range(0, 1 << 20);
    else if (r < 70) begin
      v = $urandom_range(0, 6);
      v = v - 3;
    end else v = {1'b1, 31'($urandom())};
    return v;
  endfunction

  // n counted requests (no-ops do not count) at a given idle percentage
  task automatic run_random_phase(input int n, input int idle_pct);
    int            done;
    int unsigned   r;
    logic [1:0]    act;
    int            gap;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 35) act = npst_pkg::ACT_STEP;
      else if (r < 70) act = npst_pkg::ACT_STEP_FROM;
      else if (r < 90) act = npst_pkg::ACT_SET;
      else act = npst_pkg::ACT_NONE;
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 12) : 0;
      issue_request(act, pick_value(), gap);
      if (act != npst_pkg::ACT_NONE) done++;
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: small starts, stored-value steps, extremes, no-op code
    issue_request(npst_pkg::ACT_STEP, 32'hFFFF_FFFF, 0);
    issue_request(npst_pkg::ACT_STEP, 32'd0, 0);
    issue_request(npst_pkg::ACT_STEP, 32'd12345, 1);
    issue_request(npst_pkg::ACT_STEP_FROM, 32'd0, 0);
    issue_request(npst_pkg::ACT_STEP_FROM, 32'd1, 0);
    issue_request(npst_pkg::ACT_STEP_FROM, 32'd2, 2);
    issue_request(npst_pkg::ACT_STEP_FROM, 32'd3, 0);
    issue_request(npst_pkg::ACT_STEP_FROM, 32'hFFFF_FFFF, 0);
    issue_request(npst_pkg::ACT_STEP_FROM, 32'h8000_0000, 0);
    issue_request(npst_pkg::ACT_STEP_FROM, 32'hAAAA_AAAA, 0);
    issue_request(npst_pkg::ACT_STEP_FROM, 32'hD555_5555, 0);
    issue_request(npst_pkg::ACT_SET, 32'd7, 0);
    issue_request(npst_pkg::ACT_STEP, 32'd0, 0);
    issue_request(npst_pkg::ACT_SET, 32'd8, 3);
    issue_request(npst_pkg::ACT_STEP, 32'd0, 0);
    issue_request(npst_pkg::ACT_SET, 32'h8000_0000, 0);
    issue_request(npst_pkg::ACT_STEP, 32'd0, 0);
    // largest positive start is stored, then replaced before any step
    issue_request(npst_pkg::ACT_SET, 32'h7FFF_FFFF, 0);
    issue_request(npst_pkg::ACT_NONE, 32'hFFFF_FFFF, 0);
    issue_request(npst_pkg::ACT_SET, 32'd13, 0);
    issue_request(npst_pkg::ACT_STEP, 32'd0, 0);
    issue_request(npst_pkg::ACT_STEP_FROM, 32'd89, 0);
    issue_request(npst_pkg::ACT_STEP_FROM, 32'd65535, 0);
    issue_request(npst_pkg::ACT_STEP, 32'd0, 0);
    issue_request(npst_pkg::ACT_STEP_FROM, 32'h000F_FFFF, 0);
    start <= 1'b0;
    wait_results_drained();
    @(posedge clk);

    // Random: sender idles at times, then often, then never
    run_random_phase(25, 25);
    start <= 1'b0;
    wait_results_drained();
    @(posedge clk);
    run_random_phase(25, 66);
    start <= 1'b0;
    wait_results_drained();
    @(posedge clk);
    run_random_phase(25, 0);
    start <= 1'b0;

    // Drain and let a trailing set or no-op finish
    wait_results_drained();
    while (busy) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.flag("results never seen, count", 0, sb.pending());

    $display("Covered %0d step, %0d step_from, %0d set and %0d no-op requests",
             sb.act_counts[npst_pkg::ACT_STEP], sb.act_counts[npst_pkg::ACT_STEP_FROM],
             sb.act_counts[npst_pkg::ACT_SET], sb.act_counts[npst_pkg::ACT_NONE]);
    $display("Checked %0d primes, %0d from negative starts, largest %0d",
             sb.results_checked, sb.negative_starts, sb.largest_prime);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching fields or results", sb.mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well beyond the slowest expected run
  initial begin
    #40_000_000;
    $display("Timeout: simulation did not complete");
    $display("Mismatches found");
    $finish;
  end

endmodule
